### src/mft_pkg.sv
// Shared types, constants and register codes of the Manchester frame transmitter.
`default_nettype none
package mft_pkg;

  localparam int MAX_PREAMBLE = 20;
  localparam int DATA_BITS    = 8;
  localparam int TRAILER_BITS = 3;

  localparam int PLEN_W = 5;
  localparam int CNT_W  = PLEN_W;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [PLEN_W-1:0] PREAMBLE_RESET = PLEN_W'(14);

  // register index, taken from paddr[2]
  localparam logic REG_SYNC_POLARITY   = 1'b0;
  localparam logic REG_PREAMBLE_LENGTH = 1'b1;

  typedef struct packed {
    logic              sync_polarity;
    logic [PLEN_W-1:0] preamble_length;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic run_end;
  } sym_t;

endpackage
`default_nettype wire

### src/mft_cfg_regs.sv
// APB-style configuration registers: sync polarity and preamble length.
`default_nettype none
module mft_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mft_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mft_pkg::DATA_W-1:0] pwdata,
  output logic      [mft_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output mft_pkg::cfg_t                   cfg
);
  import mft_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_polarity   <= 1'b0;
      cfg_r.preamble_length <= PREAMBLE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SYNC_POLARITY:   cfg_r.sync_polarity   <= pwdata[0];
        REG_PREAMBLE_LENGTH: cfg_r.preamble_length <= pwdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SYNC_POLARITY:   prdata = DATA_W'(cfg_r.sync_polarity);
      REG_PREAMBLE_LENGTH: prdata = DATA_W'(cfg_r.preamble_length);
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### src/mft_symbol_seq.sv
// Frame sequencer: preamble, start bit, serial data and trailer as half-bit symbols.
`default_nettype none
module mft_symbol_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mft_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_first_byte,
  input  wire logic          in_last_byte,
  input  wire logic          sym_ready,
  output logic               sym_valid,
  output mft_pkg::sym_t      sym
);
  import mft_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_START,
    ST_DATA,
    ST_TRAIL
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     half_r, half_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [PLEN_W-1:0]        plen_r, plen_nxt;
  logic [DATA_BITS-1:0]     shift_r, shift_nxt;
  logic                     sync_r, sync_nxt;
  logic                     last_r, last_nxt;

  logic              accept;
  logic              emit;
  logic              bit_val;
  logic              final_bit;
  logic [PLEN_W-1:0] plen_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign sym_valid = (state_r != ST_IDLE);
  assign emit      = sym_valid && sym_ready;

  assign plen_sat = (cfg.preamble_length > PLEN_W'(MAX_PREAMBLE)) ?
                    PLEN_W'(MAX_PREAMBLE) : cfg.preamble_length;

  always_comb begin
    case (state_r)
      ST_PRE:   bit_val = sync_r;
      ST_START: bit_val = ~sync_r;
      ST_DATA:  bit_val = shift_r[0];
      ST_TRAIL: bit_val = sync_r;
      default:  bit_val = 1'b0;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_DATA:  final_bit = (cnt_r == CNT_W'(DATA_BITS - 1)) && !last_r;
      ST_TRAIL: final_bit = (cnt_r == CNT_W'(TRAILER_BITS - 1));
      default:  final_bit = 1'b0;
    endcase
  end

  // a one goes out low then high, a zero high then low
  assign sym.line_level = half_r ? bit_val : ~bit_val;
  assign sym.run_end    = half_r && final_bit;

  always_comb begin
    state_nxt = state_r;
    half_nxt  = half_r;
    cnt_nxt   = cnt_r;
    plen_nxt  = plen_r;
    shift_nxt = shift_r;
    sync_nxt  = sync_r;
    last_nxt  = last_r;
    if (accept) begin
      shift_nxt = in_data_byte;
      sync_nxt  = cfg.sync_polarity;
      last_nxt  = in_last_byte;
      plen_nxt  = plen_sat;
      half_nxt  = 1'b0;
      cnt_nxt   = '0;
      if (!in_first_byte) begin
        state_nxt = ST_DATA;
      end else if (plen_sat == '0) begin
        state_nxt = ST_START;
      end else begin
        state_nxt = ST_PRE;
      end
    end else if (emit) begin
      half_nxt = ~half_r;
      if (half_r) begin
        case (state_r)
          ST_PRE: begin
            if (PLEN_W'(cnt_r + 1'b1) == plen_r) begin
              state_nxt = ST_START;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = CNT_W'(cnt_r + 1'b1);
            end
          end
          ST_START: begin
            state_nxt = ST_DATA;
            cnt_nxt   = '0;
          end
          ST_DATA: begin
            shift_nxt = {1'b0, shift_r[DATA_BITS-1:1]};
            if (cnt_r == CNT_W'(DATA_BITS - 1)) begin
              cnt_nxt   = '0;
              state_nxt = last_r ? ST_TRAIL : ST_IDLE;
            end else begin
              cnt_nxt = CNT_W'(cnt_r + 1'b1);
            end
          end
          ST_TRAIL: begin
            if (cnt_r == CNT_W'(TRAILER_BITS - 1)) begin
              state_nxt = ST_IDLE;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = CNT_W'(cnt_r + 1'b1);
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      half_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      half_r  <= half_nxt;
      cnt_r   <= cnt_nxt;
    end
    plen_r  <= plen_nxt;
    shift_r <= shift_nxt;
    sync_r  <= sync_nxt;
    last_r  <= last_nxt;
  end

endmodule
`default_nettype wire

### src/mft_out_reg.sv
// Output register: holds one half-bit symbol until the downstream side takes it.
`default_nettype none
module mft_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          sym_valid,
  input  wire mft_pkg::sym_t sym,
  output logic               sym_ready,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_line_level,
  output logic               out_run_end
);
  import mft_pkg::*;

  logic valid_r;
  sym_t sym_r;

  assign sym_ready      = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_line_level = sym_r.line_level;
  assign out_run_end    = sym_r.run_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sym_ready) begin
      valid_r <= sym_valid;
    end
    if (sym_ready && sym_valid) begin
      sym_r <= sym;
    end
  end

endmodule
`default_nettype wire

### src/manchester_frame_transmitter_core.sv
// Top level of the Manchester frame transmitter.
`default_nettype none
// Turns message bytes into a stream of Manchester half-bit line levels, one
// level per output transfer; a downstream pacer holds each level for a
// half-bit period. A data one goes out low then high, a zero high then low,
// data bits LSB first. A byte flagged first is preceded by a preamble of
// preamble_length sync bits (saturated at 20) and one start bit of the
// inverse value; a byte flagged last is followed by three sync-valued trailer
// bits. run_end marks the final half-bit of each byte's run. Registers sit on
// the APB-style port: sync_polarity at byte address 0, preamble_length at 4;
// write them only while the block is idle. Rate: the sequencer walks one
// half-bit per cycle while the output is not stalled, through a shift
// register and a bit counter. A byte has N half-bits (16, plus 2*(P+1) for a
// first byte with preamble P, plus 6 for a last byte); the next byte is
// accepted the cycle after the final half-bit has moved into the output
// register, while that half-bit may still wait there to be taken.
module manchester_frame_transmitter_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_first_byte,
  input  wire logic                       in_last_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_line_level,
  output logic                            out_run_end,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mft_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mft_pkg::DATA_W-1:0] pwdata,
  output logic      [mft_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import mft_pkg::*;

  cfg_t cfg;
  sym_t sym;
  logic sym_valid;
  logic sym_ready;

  // register file: sync value and preamble length
  mft_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // serial sequencer: advance one half-bit whenever the output slot frees up
  mft_symbol_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .sym_ready     (sym_ready),
    .sym_valid     (sym_valid),
    .sym           (sym)
  );

  // output register: hold the symbol while the pacer stalls
  mft_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .sym_valid      (sym_valid),
    .sym            (sym),
    .sym_ready      (sym_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_level (out_line_level),
    .out_run_end    (out_run_end)
  );

endmodule
`default_nettype wire

### src/mft_checker.sv
// Port-level checker for the Manchester frame transmitter, with its bind.
`default_nettype none
module mft_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_line_level,
  input wire logic out_run_end
);
  logic out_xfer;
  logic half_r;
  logic prev_level_r;

  assign out_xfer = out_valid && !out_stall;

  // track which half of a bit the next output transfer carries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
    end else if (out_xfer) begin
      half_r <= ~half_r;
    end
    if (out_xfer) begin
      prev_level_r <= out_line_level;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_level) && $stable(out_run_end))
    else $error("stalled output changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while a byte is in progress");

  a_manchester_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && half_r |-> out_line_level != prev_level_r)
    else $error("second half-bit does not invert the first");

  a_run_end_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_run_end |-> half_r)
    else $error("run end on a first half-bit");

endmodule

bind manchester_frame_transmitter_core mft_checker u_mft_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_line_level (out_line_level),
  .out_run_end    (out_run_end)
);
`default_nettype wire
